// File: rtl/core/sfcc_pkg.sv
// Shared types and constants for the SD/MMC frame CRC7 checker.
// No dependencies; imported by every module of the block.
package sfcc_pkg;

	localparam logic [7:0] CRC_POLY = 8'h89;
	localparam logic [3:0] LEN_F48  = 4'd5;
	localparam logic [3:0] LEN_F136 = 4'd15;

	typedef enum logic {
		KIND_F48  = 1'b0,
		KIND_F136 = 1'b1
	} frame_kind_t;

	// input register contents handed to the frame core
	typedef struct packed {
		logic       valid;
		logic [7:0] data;
	} sfcc_stage_t;

endpackage

// File: rtl/core/sfcc_ifs.sv
// Valid/ready channel interfaces: frame bytes, results, configuration.
// Standalone; used by the top level and the frame core.
interface sfcc_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	modport source (output valid, output data_byte, input ready);
	modport sink (input valid, input data_byte, output ready);
endinterface

interface sfcc_result_if;
	logic       valid;
	logic       ready;
	logic [7:0] checksum;
	logic       match;
	modport source (output valid, output checksum, output match, input ready);
	modport sink (input valid, input checksum, input match, output ready);
endinterface

interface sfcc_cfg_if;
	logic valid;
	logic ready;
	logic frame_kind;
	modport source (output valid, output frame_kind, input ready);
	modport sink (input valid, input frame_kind, output ready);
endinterface

// File: rtl/core/sfcc_crc_fold.sv
// CRC7 byte fold: eight unrolled MSB-first shift/XOR steps.
// Depends on sfcc_pkg for the polynomial mask.
module sfcc_crc_fold
	import sfcc_pkg::*;
(
	input  logic [7:0] crc,
	input  logic [7:0] data,
	output logic [7:0] crc_next
);

	always_comb begin
		logic [7:0] r;
		r = crc;
		for (int k = 7; k >= 0; k--) begin
			r = {r[6:0], 1'b0};
			// new top bit is the old bit 6; fold when it disagrees with data
			if (r[7] != data[k]) begin
				r = r ^ CRC_POLY;
			end
		end
		crc_next = r;
	end

endmodule

// File: rtl/core/sfcc_frame_core.sv
// Frame state (CRC register, byte position) and the result register.
// Depends on sfcc_pkg, sfcc_result_if and sfcc_crc_fold.
module sfcc_frame_core
	import sfcc_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  frame_kind_t   kind,
	input  sfcc_stage_t   stage,
	output logic          go,
	sfcc_result_if.source result
);

	logic [7:0] crc_q;
	logic [3:0] pos_q;
	logic       out_valid_q;
	logic [7:0] checksum_q;
	logic       match_q;

	logic [7:0] crc_folded;
	logic [3:0] len;
	logic       is_check;
	logic       load;
	logic [7:0] checksum_d;

	sfcc_crc_fold u_fold (
		.crc      (crc_q),
		.data     (stage.data),
		.crc_next (crc_folded)
	);

	assign len        = (kind == KIND_F136) ? LEN_F136 : LEN_F48;
	assign is_check   = (pos_q >= len);
	assign checksum_d = (kind == KIND_F136) ? {crc_q[6:0], 1'b1} : crc_q;
	// content bytes always drain; a check byte needs a free result slot
	assign go   = stage.valid && (!is_check || !out_valid_q || result.ready);
	assign load = go && is_check;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= '0;
			pos_q <= '0;
		end else if (go) begin
			if (is_check) begin
				crc_q <= '0;
				pos_q <= '0;
			end else begin
				crc_q <= crc_folded;
				pos_q <= pos_q + 4'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			checksum_q <= checksum_d;
			match_q    <= (checksum_d == stage.data);
		end
	end

	assign result.valid    = out_valid_q;
	assign result.checksum = checksum_q;
	assign result.match    = match_q;

	a_clear_after_check: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> (pos_q == 4'd0) && (crc_q == 8'd0))
		else $error("frame state not cleared after check byte");

	a_pos_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(go && !is_check) |=> (pos_q == $past(pos_q) + 4'd1))
		else $error("byte position did not advance on content byte");

	a_idle_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!stage.valid |=> $stable(crc_q) && $stable(pos_q))
		else $error("frame state changed with no item in the input register");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !result.ready) |-> !load)
		else $error("pending result overwritten");

endmodule

// File: rtl/core/sd_frame_crc7_check.sv
// CRC7 checker for SD/MMC frames, one byte per item.
// Channels: frame (sink of frame bytes), result (source of checksum and
// match), cfg (write of frame_kind: 0 = 48-bit frame with 5 content bytes,
// 1 = 136-bit frame with 15 content bytes).
// A frame is its content bytes followed by the received check byte; only the
// check byte yields a result item, with the computed checksum and a match
// flag, after which the CRC register and byte position clear.
// A check byte passes the input register, then the result register, before
// its result shows as valid.
// Throughput: one byte per cycle unless a check byte waits for the result
// slot; the eight-step CRC fold sits between input register and frame state.
// When the receiver stalls, the result register holds; the input register
// still takes one more byte, and content bytes keep draining. A further
// check byte waits in the input register until the result is taken.
// Reset clears frame_kind to 48-bit, the CRC register, the byte position
// and both valid flags. cfg is always ready; write it only while idle.
// Depends on sfcc_pkg, the channel interfaces and sfcc_frame_core.
module sd_frame_crc7_check
	import sfcc_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	sfcc_byte_if.sink     frame,
	sfcc_result_if.source result,
	sfcc_cfg_if.sink      cfg
);

	frame_kind_t kind_q;
	logic        valid_s1;
	logic [7:0]  data_s1;
	logic        go;
	sfcc_stage_t stage;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q <= KIND_F48;
		end else if (cfg.valid) begin
			kind_q <= frame_kind_t'(cfg.frame_kind);
		end
	end

	assign frame.ready = !valid_s1 || go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (frame.ready) begin
			valid_s1 <= frame.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (frame.valid && frame.ready) begin
			data_s1 <= frame.data_byte;
		end
	end

	assign stage.valid = valid_s1;
	assign stage.data  = data_s1;

	sfcc_frame_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.kind   (kind_q),
		.stage  (stage),
		.go     (go),
		.result (result)
	);

	a_go_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		go |-> valid_s1)
		else $error("core consumed an empty input register");

	a_hold_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !go) |=> valid_s1 && $stable(data_s1))
		else $error("blocked input item lost");

	a_cfg_applies: assert property (@(posedge clk) disable iff (!arst_n)
		cfg.valid |=> (kind_q == frame_kind_t'($past(cfg.frame_kind))))
		else $error("frame_kind write not applied");

endmodule

// File: sim/tb_top.sv
// Testbench for sd_frame_crc7_check: directed and random SD/MMC frame byte
// streams in both frame kinds; a CRC7 predictor checks each checksum and match flag.
// Depends on sfcc_pkg, the sfcc channel interfaces and the RTL top level.
module tb_top;
	import sfcc_pkg::*;

	typedef struct packed {
		logic [7:0] sum;
		logic       hit;
	} crc_verdict_t;

	logic clk;
	logic arst_n;

	sfcc_byte_if   byte_ch();
	sfcc_result_if res_ch();
	sfcc_cfg_if    cfg_ch();

	sd_frame_crc7_check dut (
		.clk    (clk),
		.arst_n (arst_n),
		.frame  (byte_ch),
		.result (res_ch),
		.cfg    (cfg_ch)
	);

	// frame state as the block should hold it
	frame_kind_t  kind_now;
	logic [7:0]   crc_acc;
	logic [3:0]   crc_pos;
	crc_verdict_t verdict_q[$];

	// stimulus generation state, synced from the frame state while idle
	frame_kind_t  gen_kind;
	logic [7:0]   gen_crc;
	logic [3:0]   gen_pos;
	logic [7:0]   byte_q[$];

	int  bytes_queued;
	int  bytes_taken;
	int  mismatch_cnt;
	int  quiet_cycles;
	int  send_gap;
	int  stall_left;
	int  hold_left;
	int  hold_reqs;
	int  holds_done;
	bit  idle_on;
	bit  calm;
	logic byte_took;

	function automatic logic [7:0] crc7_fold(logic [7:0] r, logic [7:0] b);
		for (int k = 7; k >= 0; k--) begin
			r = r << 1;
			if (r[7] != b[k])
				r = r ^ CRC_POLY;
		end
		return r;
	endfunction

	function automatic logic [7:0] frame_sum(frame_kind_t kd, logic [7:0] r);
		return (kd == KIND_F136) ? {r[6:0], 1'b1} : r;
	endfunction

	function automatic logic [3:0] content_len(frame_kind_t kd);
		return (kd == KIND_F136) ? LEN_F136 : LEN_F48;
	endfunction

	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 7))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom);
		endcase
	endfunction

	task automatic push_content(logic [7:0] b);
		byte_q.push_back(b);
		bytes_queued++;
		gen_crc = crc7_fold(gen_crc, b);
		gen_pos = gen_pos + 4'd1;
	endtask

	task automatic push_check(bit good);
		logic [7:0] s;
		s = frame_sum(gen_kind, gen_crc);
		if (!good)
			s = $urandom_range(0, 1) ? s ^ (8'h01 << $urandom_range(0, 7)) : 8'($urandom);
		byte_q.push_back(s);
		bytes_queued++;
		gen_crc = '0;
		gen_pos = '0;
	endtask

	task automatic push_random(int n);
		repeat (n) begin
			if (gen_pos >= content_len(gen_kind))
				push_check($urandom_range(0, 3) != 0);
			else
				push_content(pick_byte());
		end
	endtask

	// wait for the sender queue and all results to drain, then let the input
	// register empty out (content bytes give no result to wait on)
	task automatic settle();
		while (bytes_taken != bytes_queued || verdict_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_kind(frame_kind_t k);
		settle();
		@(negedge clk);
		cfg_ch.valid      <= 1'b1;
		cfg_ch.frame_kind <= k;
		do @(posedge clk); while (!cfg_ch.ready);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
		gen_kind = k;
		gen_crc  = crc_acc;
		gen_pos  = crc_pos;
	endtask

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		int phase;
		arst_n            = 1'b0;
		byte_ch.valid     = 1'b0;
		byte_ch.data_byte = '0;
		res_ch.ready      = 1'b0;
		cfg_ch.valid      = 1'b0;
		cfg_ch.frame_kind = 1'b0;
		bytes_queued = 0;
		idle_on      = 1'b1;
		calm         = 1'b0;
		hold_reqs    = 0;
		gen_kind     = KIND_F48;
		gen_crc      = '0;
		gen_pos      = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: CMD0 with good check, all-ones frame with bad check
		set_kind(KIND_F48);
		push_content(8'h40);
		repeat (4) push_content(8'h00);
		push_check(1'b1);
		repeat (5) push_content(8'hFF);
		push_check(1'b0);
		// 136-bit frame cut short by a switch to 48-bit: next byte is the check
		set_kind(KIND_F136);
		push_content(8'hFF);
		push_content(8'h00);
		repeat (5) push_content(pick_byte());
		set_kind(KIND_F48);
		push_check(1'b1);

		// random phases; phase boundaries often land mid-frame
		phase = 0;
		while (bytes_queued < 1350) begin
			set_kind(frame_kind_t'($urandom_range(0, 1)));
			idle_on = ($urandom_range(0, 3) != 0);
			if (phase == 2) begin
				hold_reqs++;
				push_random(160);
			end else begin
				push_random($urandom_range(20, 140));
			end
			phase++;
		end

		calm = 1'b1;
		set_kind(frame_kind_t'($urandom_range(0, 1)));
		push_random(1550 - bytes_queued);
		settle();
		repeat (4) @(posedge clk);

		if (mismatch_cnt == 0 && verdict_q.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// byte driver
	always @(negedge clk) begin : drv
		logic       nxt_valid;
		logic [7:0] nxt_data;
		nxt_valid = byte_ch.valid;
		nxt_data  = byte_ch.data_byte;
		if (!arst_n) begin
			nxt_valid = 1'b0;
			send_gap  = 0;
		end else begin
			if (byte_ch.valid && byte_took)
				nxt_valid = 1'b0;
			if (!nxt_valid) begin
				if (send_gap > 0) begin
					send_gap--;
				end else if (byte_q.size() > 0) begin
					if (idle_on && !calm && $urandom_range(0, 5) == 0) begin
						send_gap = $urandom_range(0, 9);
					end else begin
						nxt_valid = 1'b1;
						nxt_data  = byte_q.pop_front();
					end
				end
			end
		end
		byte_ch.valid     <= nxt_valid;
		byte_ch.data_byte <= nxt_data;
	end

	// result receiver
	always @(negedge clk) begin : rdy
		logic nxt_ready;
		nxt_ready = 1'b1;
		if (hold_left > 0) begin
			hold_left--;
			nxt_ready = 1'b0;
		end else if (holds_done != hold_reqs) begin
			holds_done++;
			hold_left = 299;
			nxt_ready = 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			nxt_ready = 1'b0;
		end else if (idle_on && !calm && $urandom_range(0, 6) == 0) begin
			stall_left = $urandom_range(0, 9);
			nxt_ready  = 1'b0;
		end
		res_ch.ready <= nxt_ready;
	end

	// monitor, predictor and watchdog
	initial begin
		kind_now     = KIND_F48;
		crc_acc      = '0;
		crc_pos      = '0;
		bytes_taken  = 0;
		mismatch_cnt = 0;
		quiet_cycles = 0;
		send_gap     = 0;
		stall_left   = 0;
		hold_left    = 0;
		holds_done   = 0;
		byte_took    = 1'b0;
	end

	always @(posedge clk) begin : mon
		crc_verdict_t v;
		bit           busy;
		busy = 1'b0;
		byte_took <= arst_n && byte_ch.valid && byte_ch.ready;
		if (arst_n) begin
			if (res_ch.valid && res_ch.ready) begin
				busy = 1'b1;
				if (verdict_q.size() == 0) begin
					$error("unexpected result item: checksum %02h match %0b",
						res_ch.checksum, res_ch.match);
					mismatch_cnt++;
				end else begin
					v = verdict_q.pop_front();
					if (res_ch.checksum !== v.sum) begin
						$error("checksum: expected %02h, actual %02h", v.sum, res_ch.checksum);
						mismatch_cnt++;
					end
					if (res_ch.match !== v.hit) begin
						$error("match: expected %0b, actual %0b", v.hit, res_ch.match);
						mismatch_cnt++;
					end
				end
			end
			if (byte_ch.valid && byte_ch.ready) begin
				busy = 1'b1;
				bytes_taken++;
				if (crc_pos >= content_len(kind_now)) begin
					v.sum = frame_sum(kind_now, crc_acc);
					v.hit = (v.sum == byte_ch.data_byte);
					verdict_q.push_back(v);
					crc_acc = '0;
					crc_pos = '0;
				end else begin
					crc_acc = crc7_fold(crc_acc, byte_ch.data_byte);
					crc_pos = crc_pos + 4'd1;
				end
			end
			if (cfg_ch.valid && cfg_ch.ready) begin
				busy = 1'b1;
				kind_now = frame_kind_t'(cfg_ch.frame_kind);
			end
		end
		quiet_cycles = busy ? 0 : quiet_cycles + 1;
		if (quiet_cycles >= 2000) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

endmodule

// File: filelist.f
rtl/core/sfcc_pkg.sv
rtl/core/sfcc_ifs.sv
rtl/core/sfcc_crc_fold.sv
rtl/core/sfcc_frame_core.sv
rtl/core/sd_frame_crc7_check.sv
sim/tb_top.sv
